>>> hw/rtl/ett_pkg.sv
// shared types, microcode encoding and control store for the totient block
package ett_pkg;

    localparam int UPC_W = 5;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_MP,
        OP_DIV_QP,
        OP_DIV_RP,
        OP_DIV_RM,
        OP_DIV_STEP,
        OP_SUB_R,
        OP_NEXT_P,
        OP_EMIT
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_ACCEPT,
        JC_DIV_BUSY,
        JC_Q_LT_P,
        JC_REM_NZ,
        JC_REM_Z,
        JC_M_LE_1,
        JC_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctl_word_t;

    // control store addresses
    localparam logic [UPC_W-1:0] A_IDLE       = UPC_W'(0);
    localparam logic [UPC_W-1:0] A_DIV_MP     = UPC_W'(1);
    localparam logic [UPC_W-1:0] A_RUN_MP     = UPC_W'(2);
    localparam logic [UPC_W-1:0] A_TEST_STOP  = UPC_W'(3);
    localparam logic [UPC_W-1:0] A_TEST_REM   = UPC_W'(4);
    localparam logic [UPC_W-1:0] A_STRIP      = UPC_W'(5);
    localparam logic [UPC_W-1:0] A_RUN_STRIP  = UPC_W'(6);
    localparam logic [UPC_W-1:0] A_TEST_AGAIN = UPC_W'(7);
    localparam logic [UPC_W-1:0] A_DIV_RP     = UPC_W'(8);
    localparam logic [UPC_W-1:0] A_RUN_RP     = UPC_W'(9);
    localparam logic [UPC_W-1:0] A_SUB_RP     = UPC_W'(10);
    localparam logic [UPC_W-1:0] A_NEXT       = UPC_W'(11);
    localparam logic [UPC_W-1:0] A_FINAL      = UPC_W'(12);
    localparam logic [UPC_W-1:0] A_DIV_RM     = UPC_W'(13);
    localparam logic [UPC_W-1:0] A_RUN_RM     = UPC_W'(14);
    localparam logic [UPC_W-1:0] A_SUB_RM     = UPC_W'(15);
    localparam logic [UPC_W-1:0] A_EMIT       = UPC_W'(16);
    localparam logic [UPC_W-1:0] A_RETURN     = UPC_W'(17);

    // microprogram: a true condition jumps to target, else fall through
    function automatic ctl_word_t uc_rom(input logic [UPC_W-1:0] addr);
        ctl_word_t w;
        case (addr)
            A_IDLE:       w = '{op: OP_LOAD,     cond: JC_NO_ACCEPT, target: A_IDLE};
            A_DIV_MP:     w = '{op: OP_DIV_MP,   cond: JC_NEVER,     target: A_IDLE};
            A_RUN_MP:     w = '{op: OP_DIV_STEP, cond: JC_DIV_BUSY,  target: A_RUN_MP};
            A_TEST_STOP:  w = '{op: OP_NOP,      cond: JC_Q_LT_P,    target: A_FINAL};
            A_TEST_REM:   w = '{op: OP_NOP,      cond: JC_REM_NZ,    target: A_NEXT};
            A_STRIP:      w = '{op: OP_DIV_QP,   cond: JC_NEVER,     target: A_IDLE};
            A_RUN_STRIP:  w = '{op: OP_DIV_STEP, cond: JC_DIV_BUSY,  target: A_RUN_STRIP};
            A_TEST_AGAIN: w = '{op: OP_NOP,      cond: JC_REM_Z,     target: A_STRIP};
            A_DIV_RP:     w = '{op: OP_DIV_RP,   cond: JC_NEVER,     target: A_IDLE};
            A_RUN_RP:     w = '{op: OP_DIV_STEP, cond: JC_DIV_BUSY,  target: A_RUN_RP};
            A_SUB_RP:     w = '{op: OP_SUB_R,    cond: JC_NEVER,     target: A_IDLE};
            A_NEXT:       w = '{op: OP_NEXT_P,   cond: JC_ALWAYS,    target: A_DIV_MP};
            A_FINAL:      w = '{op: OP_NOP,      cond: JC_M_LE_1,    target: A_EMIT};
            A_DIV_RM:     w = '{op: OP_DIV_RM,   cond: JC_NEVER,     target: A_IDLE};
            A_RUN_RM:     w = '{op: OP_DIV_STEP, cond: JC_DIV_BUSY,  target: A_RUN_RM};
            A_SUB_RM:     w = '{op: OP_SUB_R,    cond: JC_NEVER,     target: A_IDLE};
            A_EMIT:       w = '{op: OP_EMIT,     cond: JC_OUT_BUSY,  target: A_EMIT};
            A_RETURN:     w = '{op: OP_NOP,      cond: JC_ALWAYS,    target: A_IDLE};
            default:      w = '{op: OP_NOP,      cond: JC_ALWAYS,    target: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/euler_totient_trial_division.sv
// euler totient by trial division, run by a microcoded sequencer
//
// one beat in (number) gives one beat out (totient, number_is_prime). the number
// is factored by trial division with candidates 2, 3, then 6k-1 and 6k+1; each
// candidate p costs one division of the cofactor m by p on a shared restoring
// divider that retires one quotient bit per cycle. the search ends as soon as
// m/p < p, which bounds it near sqrt(n)/3 + 2 candidates; every prime factor
// found adds one more division per repeated power plus one to scale the
// totient, and a leftover prime cofactor adds one final division. in_ready is
// high only while the sequencer sits at its idle step, and a finished result
// waits in an output register, so the next beat is taken even while the last
// result has not been collected. zero gives totient 0, one gives totient 1,
// and neither is flagged prime. no state is kept between beats and reset
// needs no clearing pass.
module euler_totient_trial_division
    import ett_pkg::*;
#(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [NUMBER_WIDTH-1:0] number,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [NUMBER_WIDTH-1:0] totient,
    output logic                    number_is_prime
);

    localparam int NW    = NUMBER_WIDTH;
    localparam int CNT_W = $clog2(NW + 1);
    localparam int INC_W = 3;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);
    localparam logic [NW-1:0]    FIRST_P  = NW'(2);
    localparam logic [NW-1:0]    ONE      = NW'(1);
    localparam logic [NW-1:0]    LAST_LOW = NW'(3);
    localparam logic [INC_W-1:0] INC_ONE  = INC_W'(1);
    localparam logic [INC_W-1:0] INC_TWO  = INC_W'(2);
    localparam logic [INC_W-1:0] INC_SIX  = INC_W'(6);

    // sequencer
    logic [UPC_W-1:0] upc_reg, upc_next;
    ctl_word_t        ctl;

    // factoring datapath
    logic [NW-1:0]    n_reg, n_next;       // original number, for the prime flag
    logic [NW-1:0]    m_reg, m_next;       // cofactor left to factor
    logic [NW-1:0]    r_reg, r_next;       // running totient
    logic [NW-1:0]    p_reg, p_next;       // current candidate
    logic [INC_W-1:0] inc_reg, inc_next;   // step to the next candidate

    // shared divider: quo holds the dividend and shifts into the quotient
    logic [NW-1:0]    quo_reg, quo_next;
    logic [NW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW:0]      div_shift;
    logic [NW:0]      div_diff;
    logic             div_fits;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [NW-1:0]    totient_reg, totient_next;
    logic             prime_reg, prime_next;

    logic             accept;
    logic             out_busy;
    logic             emit;
    logic             jump;

    assign ctl      = uc_rom(upc_reg);
    assign in_ready = (ctl.op == OP_LOAD);
    assign accept   = in_valid && in_ready;
    assign out_busy = out_valid_reg && !out_ready;
    assign emit     = (ctl.op == OP_EMIT) && !out_busy;

    assign out_valid       = out_valid_reg;
    assign totient         = totient_reg;
    assign number_is_prime = prime_reg;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign div_shift = {rem_reg, quo_reg[NW-1]};
    assign div_diff  = div_shift - {1'b0, den_reg};
    assign div_fits  = (div_shift >= {1'b0, den_reg});

    // jump condition
    always_comb
    begin
        case (ctl.cond)
            JC_NEVER:     jump = 1'b0;
            JC_ALWAYS:    jump = 1'b1;
            JC_NO_ACCEPT: jump = !accept;
            JC_DIV_BUSY:  jump = (cnt_reg != CNT_LAST);
            JC_Q_LT_P:    jump = (quo_reg < p_reg);
            JC_REM_NZ:    jump = (rem_reg != '0);
            JC_REM_Z:     jump = (rem_reg == '0);
            JC_M_LE_1:    jump = (m_reg <= ONE);
            JC_OUT_BUSY:  jump = out_busy;
            default:      jump = 1'b0;
        endcase
    end

    assign upc_next = jump ? ctl.target : upc_reg + UPC_W'(1);

    // datapath actions for the current control word
    always_comb
    begin
        n_next       = n_reg;
        m_next       = m_reg;
        r_next       = r_reg;
        p_next       = p_reg;
        inc_next     = inc_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        cnt_next     = cnt_reg;
        totient_next = totient_reg;
        prime_next   = prime_reg;
        case (ctl.op)
            OP_LOAD:
            begin
                if (accept)
                begin
                    n_next   = number;
                    m_next   = number;
                    r_next   = number;
                    p_next   = FIRST_P;
                    inc_next = INC_ONE;
                end
            end
            OP_DIV_MP:
            begin
                quo_next = m_reg;
                rem_next = '0;
                den_next = p_reg;
                cnt_next = CNT_FULL;
            end
            OP_DIV_QP:
            begin
                // p divided m: keep the quotient and try p again
                m_next   = quo_reg;
                quo_next = quo_reg;
                rem_next = '0;
                den_next = p_reg;
                cnt_next = CNT_FULL;
            end
            OP_DIV_RP:
            begin
                quo_next = r_reg;
                rem_next = '0;
                den_next = p_reg;
                cnt_next = CNT_FULL;
            end
            OP_DIV_RM:
            begin
                quo_next = r_reg;
                rem_next = '0;
                den_next = m_reg;
                cnt_next = CNT_FULL;
            end
            OP_DIV_STEP:
            begin
                quo_next = {quo_reg[NW-2:0], div_fits};
                rem_next = div_fits ? div_diff[NW-1:0] : div_shift[NW-1:0];
                cnt_next = cnt_reg - CNT_LAST;
            end
            OP_SUB_R:
            begin
                // r times (1 - 1/p), the division is exact
                r_next = r_reg - quo_reg;
            end
            OP_NEXT_P:
            begin
                // 2, 3, 5, 7, 11, 13, ... : steps of 1, 2, then 2 and 4 in turn
                p_next   = p_reg + NW'(inc_reg);
                inc_next = (p_reg <= LAST_LOW) ? INC_TWO : INC_SIX - inc_reg;
            end
            OP_EMIT:
            begin
                if (emit)
                begin
                    totient_next = r_reg;
                    prime_next   = (n_reg > ONE) && (r_reg == n_reg - ONE);
                end
            end
            default:
            begin
            end
        endcase
    end

    // result beat stays until taken, a new one may load in the same cycle
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= A_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        m_reg       <= m_next;
        r_reg       <= r_next;
        p_reg       <= p_next;
        inc_reg     <= inc_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        cnt_reg     <= cnt_next;
        totient_reg <= totient_next;
        prime_reg   <= prime_next;
    end

endmodule

>>> hw/rtl/ett_checker.sv
// port-level checks for the totient block and their binding
module ett_checker
#(
    parameter int NUMBER_WIDTH = 32
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [NUMBER_WIDTH-1:0] totient,
    input logic                    number_is_prime
);

    localparam logic [NUMBER_WIDTH-1:0] ONE = NUMBER_WIDTH'(1);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(totient) && $stable(number_is_prime))
        else $error("result beat changed while stalled");

    // totient is even except for the numbers up to two
    a_tot_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !totient[0] || totient == ONE)
        else $error("odd totient above one");

    // a result never appears right after an input beat is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result rose one cycle after input beat");

    // when a result has just been produced the sequencer is not yet idle
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("input ready in the cycle a result appeared");

    // a number flagged prime never has a zero totient
    a_prime_tot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && number_is_prime |-> totient != '0)
        else $error("prime flagged with zero totient");

endmodule

bind euler_totient_trial_division ett_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_ett_checker (.*);

>>> test/euler_totient_trial_division_test.sv
// self-checking testbench for the trial-division euler totient block
module euler_totient_trial_division_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = 32;

    // slowest correct run is dominated by the largest 32-bit prime,
    // everything else is much shorter per beat
    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_PER_PHASE = 20;

    // idle and stall odds per random phase, in percent
    localparam int SEND_IDLE_PCT [0:3] = '{0, 87, 0, 26};
    localparam int RECV_STALL_PCT [0:3] = '{0, 0, 87, 26};

    localparam longint unsigned SMALL_PRIMES [0:24] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
        53, 59, 61, 67, 71, 73, 79, 83, 89, 97
    };

    // directed numbers: range ends, tiny values, squares and products of 6k-1 / 6k+1
    // candidates, a prime cofactor left over after the search, all-ones and
    // alternating bit patterns, and the largest 32-bit prime last since it is slow
    localparam logic [NW-1:0] EDGE_NUMBERS [0:21] = '{
        32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
        32'd25, 32'd35, 32'd49, 32'd143, 32'd169, 32'd194, 32'd30030,
        32'd65536, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF,
        32'd4294967291
    };

    // tracks expected totient beats in order and compares what comes out
    class totient_scoreboard;
        typedef struct packed {
            logic [NW-1:0] num;
            logic [NW-1:0] phi;
            logic          prime;
        } phi_beat_t;

        phi_beat_t   expected_q[$];
        int unsigned mismatches = 0;
        int unsigned checked = 0;
        int unsigned primes_seen = 0;

        // phi(n) by trial division over 2, 3, then 6k-1 and 6k+1
        static function logic [NW-1:0] phi_of(logic [NW-1:0] n);
            longint unsigned cof;
            longint unsigned acc;
            longint unsigned p;
            longint unsigned bump;
            if (n == 0)
                return '0;
            cof  = n;
            acc  = n;
            p    = 2;
            bump = 2;
            while (p * p <= cof)
            begin
                if (cof % p == 0)
                begin
                    while (cof % p == 0)
                        cof = cof / p;
                    acc = acc - acc / p;
                end
                if (p < 5)
                    p = (p == 2) ? 3 : 5;
                else
                begin
                    p    = p + bump;
                    bump = 6 - bump;
                end
            end
            // whatever is left above one is a prime factor
            if (cof > 1)
                acc = acc - acc / cof;
            return acc[NW-1:0];
        endfunction

        function void note_number(logic [NW-1:0] n);
            phi_beat_t e;
            e.num   = n;
            e.phi   = phi_of(n);
            e.prime = (n > 1) && (e.phi == n - 1);
            if (e.prime)
                primes_seen++;
            expected_q.push_back(e);
        endfunction

        task report(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(logic [NW-1:0] phi, logic prime);
            phi_beat_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing pending, totient=%0d prime=%0b",
                                 phi, prime));
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (phi !== e.phi)
                report($sformatf("number %0d: totient %0d, expected %0d", e.num, phi, e.phi));
            if (prime !== e.prime)
                report($sformatf("number %0d: prime flag %0b, expected %0b",
                                 e.num, prime, e.prime));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [NW-1:0] number = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [NW-1:0] totient;
    logic          number_is_prime;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    totient_scoreboard phi_check = new;

    euler_totient_trial_division #(
        .NUMBER_WIDTH(NW)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .number         (number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .totient        (totient),
        .number_is_prime(number_is_prime)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // receiver backpressure, redrawn every falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // result beats are taken at the rising edge where valid and ready meet
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            phi_check.check_result(totient, number_is_prime);
    end

    // drive one number beat; entered and left at a falling edge, valid is not
    // dropped at the end so back-to-back beats keep it high
    task automatic send_number(input logic [NW-1:0] n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        number   <= n;
        do
            @(posedge clk);
        while (!in_ready);
        phi_check.note_number(n);
        items_sent++;
        @(negedge clk);
    endtask

    // hold the sender off until every expected totient has come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (phi_check.pending() != 0)
            @(negedge clk);
    endtask

    // random numbers kept cheap for the block: short plain values, products of
    // small primes, and 16-bit odd cofactors, the last two shifted up so that the
    // high bits toggle without making the search long
    function automatic logic [NW-1:0] pick_number();
        longint unsigned v;
        longint unsigned p;
        int              kind;
        int              shift;
        kind = $urandom_range(2);
        case (kind)
            0: v = $urandom_range(1, (1 << $urandom_range(1, 14)) - 1);
            1:
            begin
                v = 1;
                repeat ($urandom_range(1, 6))
                begin
                    p = SMALL_PRIMES[$urandom_range(24)];
                    if (v * p <= 64'hFFFF_FFFF)
                        v = v * p;
                end
            end
            default: v = $urandom_range(1, 65535) | 1;
        endcase
        if (kind != 0)
        begin
            shift = $urandom_range(31);
            while (shift > 0 && (v << shift) > 64'hFFFF_FFFF)
                shift--;
            v = v << shift;
        end
        return v[NW-1:0];
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed numbers with no idling on either side
        foreach (EDGE_NUMBERS[i])
            send_number(EDGE_NUMBERS[i]);
        wait_all_results();

        // random phases, each drained before the next mix starts
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            repeat (RANDOM_PER_PHASE)
                send_number(pick_number());
            wait_all_results();
        end

        // watch for stray result beats after the last one
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("drove %0d numbers (%0d prime) from one to the largest 32-bit prime,",
                 items_sent, phi_check.primes_seen);
        $display("checked %0d totient beats under free-flowing, idle and stall mixes in %0d cycles",
                 phi_check.checked, cycle_count);
        if (phi_check.mismatches == 0)
            $display("[euler_totient_trial_division] OK");
        else
            $display("[euler_totient_trial_division] ERROR");
        $finish;
    end

    // run-length guard
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d beats still pending",
                 cycle_count, phi_check.pending());
        $display("[euler_totient_trial_division] ERROR");
        $finish;
    end

endmodule
